// ----- design/bjsff_pkg.sv -----
package bjsff_pkg;

    localparam int ID_W    = 8;
    localparam int ARR_W   = 16;
    localparam int BURST_W = 12;
    localparam int PRIO_W  = 8;
    localparam int TIME_W  = 19;
    localparam int BLK_W   = 3;
    localparam int MODE_W  = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;
    localparam int NUM_SIZE_REGS = 5;

    localparam logic [MODE_W-1:0] MODE_FCFS = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SJF  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_PRIO = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_0 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_4 = 3'd5;

    localparam logic [BURST_W-1:0] SIZE_RESET_0 = 12'd100;
    localparam logic [BURST_W-1:0] SIZE_RESET_1 = 12'd500;
    localparam logic [BURST_W-1:0] SIZE_RESET_2 = 12'd200;
    localparam logic [BURST_W-1:0] SIZE_RESET_3 = 12'd300;
    localparam logic [BURST_W-1:0] SIZE_RESET_4 = 12'd600;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [ARR_W-1:0]   arrival;
        logic [BURST_W-1:0] burst;
        logic [PRIO_W-1:0]  prio;
    } job_rec_t;

    typedef struct packed {
        logic [ID_W-1:0]    job_id;
        logic [ARR_W-1:0]   arrival_time;
        logic [BURST_W-1:0] burst_length;
        logic [PRIO_W-1:0]  job_priority;
        logic               final_job;
    } job_in_t;

    typedef struct packed {
        logic [ID_W-1:0]   out_job_id;
        logic              rejected;
        logic [BLK_W-1:0]  blk_grant;
        logic [TIME_W-1:0] start_time;
        logic [TIME_W-1:0] completion_time;
        logic [TIME_W-1:0] response_time;
        logic [TIME_W-1:0] waiting_time;
        logic [TIME_W-1:0] turnaround_time;
        logic              last_result;
    } job_out_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_MIN_SCAN,
        ST_PICK_SCAN,
        ST_READ,
        ST_FIT,
        ST_EMIT,
        ST_WAIT_OUT
    } ctrl_state_t;

    // Controller to datapath
    typedef struct packed {
        logic store;       // write input item into table
        logic scan_clear;  // reset scan index and scan results
        logic scan_step;   // evaluate one entry and advance
        logic min_scan;    // 1: earliest-arrival scan, 0: pick scan
        logic clock_jump;  // raise clock: FCFS to picked arrival, else earliest
        logic read_pick;   // fetch picked entry from table
        logic fit_step;    // test one block and advance
        logic emit;        // load output register, mark job done
        logic run_clear;   // end of run, clear count/flags/clock
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic scan_last;   // current entry is the last stored one
        logic any_left;    // an unfinished job exists
        logic pick_found;  // FCFS pick scan found a job
        logic fit_done;    // block search finished
        logic job_empty;   // no jobs stored
        logic out_busy;    // output register holds an untaken result
    } dp_sts_t;

endpackage

// ----- design/bjsff_if.sv -----
interface bjsff_job_if;
    import bjsff_pkg::*;
    logic    valid;
    logic    ready;
    job_in_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface bjsff_res_if;
    import bjsff_pkg::*;
    logic     valid;
    logic     ready;
    job_out_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface bjsff_cfg_if;
    import bjsff_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] wdata;
    modport source (output valid, output index, output wdata, input ready);
    modport sink (input valid, input index, input wdata, output ready);
endinterface

// ----- design/batch_job_scheduler_first_fit_unit.sv -----
// Batch job scheduler with first-fit block grant.
//
// Channels: job_in (sink) takes one job record per transaction; a record
// with final_job set closes the batch and starts scheduling. result (source)
// returns one transaction per stored job in dispatch order; last_result
// marks the final one. cfg (sink) writes mode (index 0) and the five block
// capacities (indexes 1..5); write only while no batch is in progress.
//
// Sequence: a load stores one record per accepted transaction. Each dispatch
// runs an earliest-arrival scan over the stored jobs, a pick scan (FCFS stops
// at the first unfinished job), a read of the chosen record, a block search
// and an emit; each result is presented the cycle after its emit. After the
// last result one more earliest-arrival scan and a closing step end the run
// before job_in is ready again. The table scan evaluates one entry per cycle.
//
// Reset clears the job count, done flags, clock and configuration to the
// reset capacities 100/500/200/300/600 and FCFS mode. When the result
// receiver stalls, scheduling holds in front of the output register.
module batch_job_scheduler_first_fit_unit #(
    parameter int MAX_JOBS = 16,
    parameter int BLOCKS   = 5
) (
    input  logic         clk,
    input  logic         rst_n,
    bjsff_job_if.sink    job_in,
    bjsff_res_if.source  result,
    bjsff_cfg_if.sink    cfg
);
    import bjsff_pkg::*;

    logic [MODE_W-1:0]                 mode_reg;
    logic [NUM_SIZE_REGS-1:0][BURST_W-1:0] size_reg;
    logic [BLOCKS-1:0][BURST_W-1:0]    sizes;
    dp_cmd_t                           cmd;
    dp_sts_t                           sts;
    logic                              dp_valid;
    job_out_t                          dp_data;

    assign cfg.ready = 1'b1;

    // Configuration registers; writes beyond the list are ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_FCFS;
            size_reg[0] <= SIZE_RESET_0;
            size_reg[1] <= SIZE_RESET_1;
            size_reg[2] <= SIZE_RESET_2;
            size_reg[3] <= SIZE_RESET_3;
            size_reg[4] <= SIZE_RESET_4;
        end
        else if (cfg.valid)
        begin
            if (cfg.index == REG_MODE)
            begin
                mode_reg <= cfg.wdata[MODE_W-1:0];
            end
            else if (cfg.index >= REG_SIZE_0 && cfg.index <= REG_SIZE_4)
            begin
                size_reg[cfg.index - REG_SIZE_0] <= cfg.wdata;
            end
        end
    end

    // Blocks beyond the five registers have capacity zero
    for (genvar b = 0; b < BLOCKS; b++)
    begin : g_size
        if (b < NUM_SIZE_REGS)
        begin : g_reg
            assign sizes[b] = size_reg[b];
        end
        else
        begin : g_zero
            assign sizes[b] = '0;
        end
    end

    assign result.valid = dp_valid;
    assign result.data  = dp_data;

    bjsff_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (job_in.valid),
        .in_final (job_in.data.final_job),
        .in_ready (job_in.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    bjsff_dp #(
        .MAX_JOBS (MAX_JOBS),
        .BLOCKS   (BLOCKS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (job_in.data),
        .mode      (mode_reg),
        .sizes     (sizes),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (dp_valid),
        .out_ready (result.ready),
        .out_data  (dp_data)
    );

`ifndef NO_ASSERTIONS
    // Hold a stalled result and its payload until it is taken
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.ready) |=> (result.valid && $stable(result.data)))
        else $error("stalled result changed");

    a_emit_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> !(dp_valid && !result.ready))
        else $error("result overwritten before taken");

    a_emit_presents: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> result.valid)
        else $error("emitted result not presented");
`endif

endmodule

// ----- design/bjsff_ctrl.sv -----
module bjsff_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_final,
    output logic                in_ready,
    input  bjsff_pkg::dp_sts_t  sts,
    output bjsff_pkg::dp_cmd_t  cmd
);
    import bjsff_pkg::*;

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_LOAD:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.store = 1'b1;
                    if (in_final)
                    begin
                        cmd.scan_clear = 1'b1;
                        state_next     = ST_MIN_SCAN;
                    end
                end
            end
            ST_MIN_SCAN:
            begin
                if (sts.job_empty)
                begin
                    cmd.run_clear = 1'b1;
                    state_next    = ST_LOAD;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                    cmd.min_scan  = 1'b1;
                    if (sts.scan_last)
                    begin
                        state_next = ST_PICK_SCAN;
                    end
                end
            end
            ST_PICK_SCAN:
            begin
                if (!sts.any_left)
                begin
                    cmd.run_clear = 1'b1;
                    state_next    = ST_LOAD;
                end
                else
                begin
                    cmd.clock_jump = 1'b1;
                    cmd.scan_step  = 1'b1;
                    if (sts.scan_last || sts.pick_found)
                    begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                cmd.read_pick = 1'b1;
                state_next    = ST_FIT;
            end
            ST_FIT:
            begin
                cmd.fit_step = 1'b1;
                if (sts.fit_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!sts.out_busy)
                begin
                    cmd.emit       = 1'b1;
                    cmd.scan_clear = 1'b1;
                    state_next     = ST_MIN_SCAN;
                end
            end
            ST_WAIT_OUT:
            begin
                state_next = ST_LOAD;
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

endmodule

// ----- design/bjsff_dp.sv -----
module bjsff_dp #(
    parameter int MAX_JOBS = 16,
    parameter int BLOCKS   = 5
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  bjsff_pkg::job_in_t                  in_data,
    input  logic [bjsff_pkg::MODE_W-1:0]        mode,
    input  logic [BLOCKS-1:0][bjsff_pkg::BURST_W-1:0] sizes,
    input  bjsff_pkg::dp_cmd_t                  cmd,
    output bjsff_pkg::dp_sts_t                  sts,
    output logic                                out_valid,
    input  logic                                out_ready,
    output bjsff_pkg::job_out_t                 out_data
);
    import bjsff_pkg::*;

    localparam int IDX_W = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
    localparam int CNT_W = $clog2(MAX_JOBS + 1);
    localparam int BI_W  = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;
    localparam int BC_W  = $clog2(BLOCKS + 1);

    job_rec_t job_mem [MAX_JOBS];

    logic [MAX_JOBS-1:0] done_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    emit_cnt_reg;
    logic [TIME_W-1:0]   clock_reg;
    logic [CNT_W-1:0]    scan_reg;
    logic                any_reg;
    logic [ARR_W-1:0]    min_arr_reg;
    logic                best_ok_reg;
    logic [IDX_W-1:0]    best_reg;
    logic [BURST_W-1:0]  best_key_reg;
    logic                jumped_reg;
    job_rec_t            rd_reg;
    job_rec_t            scan_rd_reg;
    logic [BC_W-1:0]     blk_reg;
    logic                fit_ok_reg;
    logic                fit_done_reg;
    logic                out_valid_reg;
    job_out_t            out_reg;

    logic [IDX_W-1:0]    scan_idx;
    logic [CNT_W-1:0]    scan_next;
    logic                wr_en;
    job_rec_t            wr_rec;
    logic                fcfs;
    logic [BURST_W-1:0]  key;
    logic                entry_live;
    logic                eligible;
    logic [TIME_W-1:0]   clock_eff;
    logic [TIME_W-1:0]   arr_ext;
    logic [TIME_W-1:0]   done_time;
    logic [BI_W-1:0]     blk_idx;
    logic                run_end;
    logic                last_pick;

    assign scan_idx   = scan_reg[IDX_W-1:0];
    assign scan_next  = cmd.scan_clear ? '0
                      : cmd.scan_step ? (sts.scan_last ? '0 : scan_reg + CNT_W'(1))
                      : scan_reg;
    assign wr_en      = cmd.store && (count_reg < CNT_W'(MAX_JOBS));
    assign wr_rec     = '{id: in_data.job_id, arrival: in_data.arrival_time,
                          burst: in_data.burst_length, prio: in_data.job_priority};
    assign fcfs       = (mode != MODE_SJF) && (mode != MODE_PRIO);
    assign entry_live = !done_reg[scan_idx];
    assign key        = (mode == MODE_SJF) ? scan_rd_reg.burst
                                           : {{(BURST_W-PRIO_W){1'b0}}, scan_rd_reg.prio};
    assign arr_ext    = {{(TIME_W-ARR_W){1'b0}}, scan_rd_reg.arrival};
    // Clock as seen by the pick scan: raised to earliest arrival in SJF/priority
    assign clock_eff  = (!fcfs && clock_reg < {{(TIME_W-ARR_W){1'b0}}, min_arr_reg})
                        ? {{(TIME_W-ARR_W){1'b0}}, min_arr_reg} : clock_reg;
    assign eligible   = entry_live && (fcfs || arr_ext <= clock_eff);
    assign blk_idx    = blk_reg[BI_W-1:0];
    assign done_time  = clock_reg + {{(TIME_W-BURST_W){1'b0}}, rd_reg.burst};
    assign run_end    = cmd.run_clear;
    // Every stored job yields one result, so the count tells the final one
    assign last_pick  = (emit_cnt_reg == count_reg - CNT_W'(1));

    assign sts.scan_last  = (scan_reg == count_reg - CNT_W'(1));
    assign sts.any_left   = any_reg;
    assign sts.pick_found = fcfs && eligible;
    assign sts.fit_done   = fit_done_reg;
    assign sts.job_empty  = (count_reg == '0);
    assign sts.out_busy   = out_valid_reg && !out_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Table write; the scan read follows the index the scan moves to, so the
    // registered entry always matches scan_reg
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            job_mem[count_reg[IDX_W-1:0]] <= wr_rec;
        end
        if (wr_en && count_reg[IDX_W-1:0] == scan_next[IDX_W-1:0])
        begin
            scan_rd_reg <= wr_rec;
        end
        else
        begin
            scan_rd_reg <= job_mem[scan_next[IDX_W-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg      <= '0;
            count_reg     <= '0;
            emit_cnt_reg  <= '0;
            clock_reg     <= '0;
            scan_reg      <= '0;
            any_reg       <= 1'b0;
            min_arr_reg   <= '0;
            best_ok_reg   <= 1'b0;
            best_reg      <= '0;
            best_key_reg  <= '0;
            blk_reg       <= '0;
            fit_ok_reg    <= 1'b0;
            fit_done_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            jumped_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (wr_en)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            scan_reg <= scan_next;
            if (cmd.scan_clear)
            begin
                any_reg     <= 1'b0;
                best_ok_reg <= 1'b0;
                jumped_reg  <= 1'b0;
            end
            if (cmd.scan_step)
            begin
                if (cmd.min_scan)
                begin
                    if (entry_live)
                    begin
                        any_reg <= 1'b1;
                        if (!any_reg || scan_rd_reg.arrival < min_arr_reg)
                        begin
                            min_arr_reg <= scan_rd_reg.arrival;
                        end
                    end
                end
                else
                begin
                    if (eligible && (!best_ok_reg || key < best_key_reg))
                    begin
                        best_ok_reg  <= 1'b1;
                        best_reg     <= scan_idx;
                        best_key_reg <= key;
                    end
                end
            end
            if (cmd.clock_jump)
            begin
                // FCFS waits for the picked job; the others jump once per pick
                if (fcfs && eligible && clock_eff < arr_ext)
                begin
                    clock_reg <= arr_ext;
                end
                else if (!jumped_reg)
                begin
                    clock_reg <= clock_eff;
                end
                jumped_reg <= 1'b1;
            end
            if (cmd.read_pick)
            begin
                blk_reg      <= '0;
                fit_ok_reg   <= 1'b0;
                fit_done_reg <= 1'b0;
            end
            if (cmd.fit_step && !fit_done_reg)
            begin
                if (blk_reg == BC_W'(BLOCKS))
                begin
                    fit_done_reg <= 1'b1;
                end
                else if (sizes[blk_idx] >= rd_reg.burst)
                begin
                    fit_ok_reg   <= 1'b1;
                    fit_done_reg <= 1'b1;
                end
                else
                begin
                    blk_reg <= blk_reg + BC_W'(1);
                end
            end
            if (cmd.emit)
            begin
                done_reg[best_reg] <= 1'b1;
                fit_done_reg       <= 1'b0;
                emit_cnt_reg       <= emit_cnt_reg + CNT_W'(1);
                if (fit_ok_reg)
                begin
                    clock_reg <= done_time;
                end
            end
            if (run_end)
            begin
                done_reg     <= '0;
                count_reg    <= '0;
                emit_cnt_reg <= '0;
                clock_reg    <= '0;
            end
        end
    end

    // Picked record and output payload
    always_ff @(posedge clk)
    begin
        if (cmd.read_pick)
        begin
            rd_reg <= job_mem[best_reg];
        end
        if (cmd.emit)
        begin
            out_reg.out_job_id  <= rd_reg.id;
            out_reg.last_result <= last_pick;
            out_reg.rejected    <= !fit_ok_reg;
            if (fit_ok_reg)
            begin
                out_reg.blk_grant       <= BLK_W'(blk_reg);
                out_reg.start_time      <= clock_reg;
                out_reg.completion_time <= done_time;
                out_reg.response_time   <= clock_reg - {{(TIME_W-ARR_W){1'b0}}, rd_reg.arrival};
                out_reg.waiting_time    <= clock_reg - {{(TIME_W-ARR_W){1'b0}}, rd_reg.arrival};
                out_reg.turnaround_time <= done_time - {{(TIME_W-ARR_W){1'b0}}, rd_reg.arrival};
            end
            else
            begin
                out_reg.blk_grant       <= '0;
                out_reg.start_time      <= '0;
                out_reg.completion_time <= '0;
                out_reg.response_time   <= '0;
                out_reg.waiting_time    <= '0;
                out_reg.turnaround_time <= '0;
            end
        end
    end

endmodule

// ----- tb/bjsff_tb_if.sv -----
`timescale 1ns / 100ps

// Handshake probe: flags a transaction accepted at the current edge.
module bjsff_tb_if_probe (
    input logic valid,
    input logic ready,
    output logic fire
);
    assign fire = valid & ready;
endmodule

// ----- tb/batch_job_scheduler_first_fit_unit_tb.sv -----
`timescale 1ns / 100ps

module batch_job_scheduler_first_fit_unit_tb;
    import bjsff_pkg::*;

    localparam int MAX_JOBS = 16;
    localparam int NUM_BLOCKS = 5;

    typedef struct {
        logic is_cfg;
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_DATA_W-1:0] val;
        job_in_t job;
    } work_t;

    logic clk;
    logic rst_n;
    logic job_fire;

    bjsff_job_if job_ch ();
    bjsff_res_if res_ch ();
    bjsff_cfg_if cfg_ch ();

    batch_job_scheduler_first_fit_unit #(
        .MAX_JOBS(MAX_JOBS),
        .BLOCKS(NUM_BLOCKS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .job_in(job_ch.sink),
        .result(res_ch.source),
        .cfg(cfg_ch.sink)
    );

    // Predictor copy of the block's state and configuration.
    logic [MODE_W-1:0] sched_mode;
    logic [BURST_W-1:0] blk_cap[NUM_BLOCKS];
    job_rec_t batch_tbl[MAX_JOBS];
    bit batch_done[MAX_JOBS];
    int batch_len;

    work_t pending_work[$];
    job_out_t expected_reports[$];
    int err_count = 0;
    bit quiet_tail;
    bit stall_hold;
    int send_gap;
    int recv_gap;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(input string what);
        err_count++;
        $display("MISMATCH @%0t: %s", $realtime, what);
    endtask

    // Load one job and, on the final mark, run the whole schedule.
    task automatic predict_job(input job_in_t j);
        int pick;
        int blk;
        logic [TIME_W-1:0] now;
        logic [TIME_W-1:0] earliest;
        logic [TIME_W-1:0] stop;
        logic [11:0] best_key;
        logic [11:0] key;
        bit any;
        job_out_t r;
        job_out_t last_r;
        int produced;
        if (batch_len < MAX_JOBS)
        begin
            batch_tbl[batch_len] = '{j.job_id, j.arrival_time, j.burst_length,
                                     j.job_priority};
            batch_done[batch_len] = 0;
            batch_len++;
        end
        if (!j.final_job)
            return;
        now = '0;
        produced = 0;
        forever
        begin
            any = 0;
            earliest = '0;
            for (int i = 0; i < batch_len; i++)
                if (!batch_done[i])
                begin
                    if (!any || batch_tbl[i].arrival < earliest)
                        earliest = batch_tbl[i].arrival;
                    any = 1;
                end
            if (!any)
                break;
            pick = -1;
            if (sched_mode != MODE_SJF && sched_mode != MODE_PRIO)
            begin
                for (int i = 0; i < batch_len && pick < 0; i++)
                    if (!batch_done[i])
                        pick = i;
                if (now < batch_tbl[pick].arrival)
                    now = batch_tbl[pick].arrival;
            end
            else
            begin
                if (now < earliest)
                    now = earliest;
                best_key = '0;
                for (int i = 0; i < batch_len; i++)
                begin
                    if (batch_done[i] || batch_tbl[i].arrival > now)
                        continue;
                    key = (sched_mode == MODE_SJF) ? batch_tbl[i].burst
                                                   : 12'(batch_tbl[i].prio);
                    if (pick < 0 || key < best_key)
                    begin
                        pick = i;
                        best_key = key;
                    end
                end
            end
            blk = -1;
            for (int b = 0; b < NUM_BLOCKS && blk < 0; b++)
                if (blk_cap[b] >= batch_tbl[pick].burst)
                    blk = b;
            batch_done[pick] = 1;
            r = '0;
            r.out_job_id = batch_tbl[pick].id;
            if (blk < 0)
                r.rejected = 1'b1;
            else
            begin
                stop = now + batch_tbl[pick].burst;
                r.blk_grant = BLK_W'(blk);
                r.start_time = now;
                r.completion_time = stop;
                r.response_time = now - batch_tbl[pick].arrival;
                r.waiting_time = stop - batch_tbl[pick].arrival - batch_tbl[pick].burst;
                r.turnaround_time = stop - batch_tbl[pick].arrival;
                now = stop;
            end
            if (produced > 0)
                expected_reports.push_back(last_r);
            last_r = r;
            produced++;
        end
        if (produced > 0)
        begin
            last_r.last_result = 1'b1;
            expected_reports.push_back(last_r);
        end
        batch_len = 0;
    endtask

    function automatic job_in_t rand_job(input bit fin, input int burst_hi);
        job_in_t j;
        j.job_id = 8'($urandom);
        j.arrival_time = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                     : 16'($urandom_range(0, 300));
        j.burst_length = 12'($urandom_range(0, burst_hi));
        j.job_priority = 8'($urandom);
        j.final_job = fin;
        return j;
    endfunction

    task automatic queue_job(input job_in_t j);
        work_t w;
        w.is_cfg = 0;
        w.idx = '0;
        w.val = '0;
        w.job = j;
        pending_work.push_back(w);
    endtask

    task automatic queue_cfg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        work_t w;
        w.is_cfg = 1;
        w.idx = idx;
        w.val = val;
        w.job = '0;
        pending_work.push_back(w);
    endtask

    // Block until the driver has drained the queue and every report arrived.
    task automatic wait_drained();
        while (pending_work.size() != 0 || job_ch.valid || cfg_ch.valid ||
               expected_reports.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    // Driver: one transaction per item, configuration writes only when idle.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_ch.valid <= 1'b0;
            job_ch.data <= '0;
            cfg_ch.valid <= 1'b0;
            cfg_ch.index <= '0;
            cfg_ch.wdata <= '0;
            send_gap <= 0;
            sched_mode = MODE_FCFS;
            blk_cap = '{SIZE_RESET_0, SIZE_RESET_1, SIZE_RESET_2, SIZE_RESET_3,
                        SIZE_RESET_4};
            batch_len = 0;
        end
        else
        begin
            if (job_fire)
                predict_job(job_ch.data);
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                if (cfg_ch.index == REG_MODE)
                    sched_mode = cfg_ch.wdata[MODE_W-1:0];
                else
                    blk_cap[cfg_ch.index - REG_SIZE_0] = cfg_ch.wdata;
            end
            if ((job_ch.valid && !job_ch.ready) || (cfg_ch.valid && !cfg_ch.ready))
                ; // hold the offered transaction
            else if (send_gap > 0)
            begin
                send_gap <= send_gap - 1;
                job_ch.valid <= 1'b0;
                cfg_ch.valid <= 1'b0;
            end
            else if (pending_work.size() != 0 &&
                     (!pending_work[0].is_cfg ||
                      (expected_reports.size() == 0 && !job_ch.valid)))
            begin
                work_t w;
                w = pending_work.pop_front();
                job_ch.valid <= !w.is_cfg;
                job_ch.data <= w.job;
                cfg_ch.valid <= w.is_cfg;
                cfg_ch.index <= w.idx;
                cfg_ch.wdata <= w.val;
                if (!quiet_tail && $urandom_range(0, 5) == 0)
                    send_gap <= $urandom_range(1, 8);
            end
            else
            begin
                job_ch.valid <= 1'b0;
                cfg_ch.valid <= 1'b0;
            end
        end
    end

    // Monitor: compare each result transaction with the oldest expectation.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
            recv_gap <= 0;
        end
        else
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                if (expected_reports.size() == 0)
                    report_mismatch($sformatf("unexpected result id %0d",
                                              res_ch.data.out_job_id));
                else
                begin
                    job_out_t e;
                    job_out_t g;
                    e = expected_reports.pop_front();
                    g = res_ch.data;
                    if (g.out_job_id !== e.out_job_id)
                        report_mismatch($sformatf("id %0d exp %0d", g.out_job_id, e.out_job_id));
                    if (g.rejected !== e.rejected)
                        report_mismatch($sformatf("id %0d rejected %0b exp %0b",
                                                  e.out_job_id, g.rejected, e.rejected));
                    if (g.blk_grant !== e.blk_grant)
                        report_mismatch($sformatf("id %0d block %0d exp %0d",
                                                  e.out_job_id, g.blk_grant, e.blk_grant));
                    if (g.start_time !== e.start_time)
                        report_mismatch($sformatf("id %0d start %0d exp %0d",
                                                  e.out_job_id, g.start_time, e.start_time));
                    if (g.completion_time !== e.completion_time)
                        report_mismatch($sformatf("id %0d completion %0d exp %0d", e.out_job_id,
                                                  g.completion_time, e.completion_time));
                    if (g.response_time !== e.response_time)
                        report_mismatch($sformatf("id %0d response %0d exp %0d", e.out_job_id,
                                                  g.response_time, e.response_time));
                    if (g.waiting_time !== e.waiting_time)
                        report_mismatch($sformatf("id %0d waiting %0d exp %0d", e.out_job_id,
                                                  g.waiting_time, e.waiting_time));
                    if (g.turnaround_time !== e.turnaround_time)
                        report_mismatch($sformatf("id %0d turnaround %0d exp %0d", e.out_job_id,
                                                  g.turnaround_time, e.turnaround_time));
                    if (g.last_result !== e.last_result)
                        report_mismatch($sformatf("id %0d last %0b exp %0b",
                                                  e.out_job_id, g.last_result, e.last_result));
                end
            end
            // Stall in random bursts, or hold off entirely while asked to.
            if (stall_hold)
                res_ch.ready <= 1'b0;
            else if (recv_gap > 0)
            begin
                recv_gap <= recv_gap - 1;
                res_ch.ready <= 1'b0;
            end
            else if (!quiet_tail && $urandom_range(0, 6) == 0)
            begin
                recv_gap <= $urandom_range(0, 7);
                res_ch.ready <= 1'b0;
            end
            else
                res_ch.ready <= 1'b1;
        end
    end

    // Long receiver hold-off, counted here in cycles.
    initial
    begin
        stall_hold = 0;
        wait (rst_n);
        repeat (3000) @(posedge clk);
        stall_hold = 1;
        repeat (400) @(posedge clk);
        stall_hold = 0;
    end

    initial
    begin
        #50ms;
        $display("batch_job_scheduler_first_fit_unit_tb: done, errors");
        $finish;
    end

    initial
    begin
        job_in_t j;
        int n;
        quiet_tail = 0;
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: field extremes, idle jump, rejection, under reset sizes.
        queue_job('{8'hFF, 16'hFFFF, 12'd50, 8'h00, 1'b0});
        queue_job('{8'h00, 16'h0000, 12'd0, 8'hFF, 1'b0});
        queue_job('{8'h55, 16'h0010, 12'd4095, 8'h80, 1'b0});
        queue_job('{8'hAA, 16'h0020, 12'd550, 8'h7F, 1'b1});
        queue_job('{8'h11, 16'h0005, 12'd600, 8'h01, 1'b1});
        // Table overflow: 20 jobs, the last four dropped; the final one still starts.
        for (int i = 0; i < 20; i++)
            queue_job('{8'(i), 16'(i * 3), 12'(i * 37), 8'(20 - i), i == 19});
        wait_drained();

        // Run through several settings, extremes included, with random batches under each.
        for (int phase = 0; phase < 8; phase++)
        begin
            logic [MODE_W-1:0] m;
            m = (phase == 7) ? 2'd3 : MODE_W'(phase % 3);
            queue_cfg(REG_MODE, CFG_DATA_W'(m));
            for (int b = 0; b < NUM_BLOCKS; b++)
                queue_cfg(REG_SIZE_0 + CFG_IDX_W'(b),
                          phase == 1 ? 12'd0 : phase == 2 ? 12'd4095 : 12'($urandom_range(0, 4095)));
            if (phase == 6)
                quiet_tail = 1;
            for (int k = 0; k < 7; k++)
            begin
                n = ($urandom_range(0, 5) == 0) ? $urandom_range(10, 18) : $urandom_range(1, 6);
                for (int i = 0; i < n; i++)
                begin
                    j = rand_job(i == n - 1, ($urandom_range(0, 3) == 0) ? 4095 : 700);
                    queue_job(j);
                end
            end
            // Sender pause until every expected result has come.
            wait_drained();
        end

        repeat (50) @(posedge clk);
        if (err_count == 0 && expected_reports.size() == 0)
            $display("batch_job_scheduler_first_fit_unit_tb: done, clean");
        else
            $display("batch_job_scheduler_first_fit_unit_tb: done, errors");
        $finish;
    end

    bjsff_tb_if_probe job_probe (.valid(job_ch.valid), .ready(job_ch.ready),
                                 .fire(job_fire));
endmodule

// ----- sim.f -----
design/bjsff_pkg.sv
design/bjsff_if.sv
design/bjsff_ctrl.sv
design/bjsff_dp.sv
design/batch_job_scheduler_first_fit_unit.sv
tb/bjsff_tb_if.sv
tb/batch_job_scheduler_first_fit_unit_tb.sv
